[hw/rtl/assert_macros.svh]
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk_i, disabled in reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define UTCL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UTCL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/utcl_pkg.sv]
// -----------------------------------------------------------------------------
// utcl_pkg
// Constants, register codes and small helpers for the UTC to local time block.
// -----------------------------------------------------------------------------
package utcl_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ZONE_HOURS     = 2'd0,
    CFG_DST_ENABLE     = 2'd1,
    CFG_OFFSET_MINUTES = 2'd2
  } cfg_reg_e;

  // floor(x / 675) = (x * DayRecip) >> DayShift, exact for x < 2**26
  localparam int unsigned DayShift = 36;
  localparam logic [26:0] DayRecip =
    27'(((64'd1 << DayShift) + 64'd674) / 64'd675);

  // floor(c / 1461) = (c * CycRecip) >> 32, exact for c < 2**16
  localparam logic [21:0] CycRecip = 22'(((64'd1 << 32) + 64'd1460) / 64'd1461);

  // day count from 1968-03-01 is qd + CivilBase, qd = days since epoch + 1
  localparam logic [16:0] CivilBase = 17'd670;
  // first day after the missing 2100-02-29
  localparam logic [16:0] Day2100   = 17'd48212;

  // March-based month codes
  localparam logic [3:0] MpMarch = 4'd0;
  localparam logic [3:0] MpOct   = 4'd7;
  localparam logic [3:0] MpNov   = 4'd8;

  // first day of year (March-based) of each month
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    unique case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // v mod 7 by summing octal digits (8 = 1 mod 7)
  function automatic logic [2:0] mod7_18(input logic [17:0] v);
    logic [5:0] s;
    logic [3:0] f;
    s = '0;
    for (int i = 0; i < 6; i++) begin
      s = s + {3'b000, v[3*i +: 3]};
    end
    f = {1'b0, s[5:3]} + {1'b0, s[2:0]};
    if (f >= 4'd7) begin
      f = f - 4'd7;
    end
    return f[2:0];
  endfunction

endpackage

[hw/rtl/utc_to_local_time_with_dst.sv]
// -----------------------------------------------------------------------------
// utc_to_local_time_with_dst
// UTC epoch seconds to local seconds with zone, North American DST and a
// minute trim.
// -----------------------------------------------------------------------------
// One timestamp is taken per clock: busy stays low and a word is accepted on
// every cycle with start high. Each result appears on local_seconds_o and
// dst_active_o for exactly one cycle with done_o high; results leave in input
// order and cannot be held off, so the receiver must take every done_o cycle.
// The results come from an 8-stage pipeline built around two reciprocal
// multipliers (day split and four-year cycle split). Configuration writes take
// effect at once; write only while no word is in flight.
`include "assert_macros.svh"

module utc_to_local_time_with_dst (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [31:0]                          utc_seconds_i,
  output logic                                 done_o,
  output logic signed [33:0]                   local_seconds_o,
  output logic                                 dst_active_o,
  input  logic                                 cfg_we_i,
  input  logic [utcl_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [utcl_pkg::CfgDataW-1:0]        cfg_data_i
);
  import utcl_pkg::*;

  // configuration
  logic signed [4:0]  zone_hours_q;
  logic               dst_enable_q;
  logic signed [10:0] offset_minutes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_hours_q     <= '0;
      dst_enable_q     <= 1'b0;
      offset_minutes_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_ZONE_HOURS:     zone_hours_q     <= cfg_data_i[4:0];
        CFG_DST_ENABLE:     dst_enable_q     <= cfg_data_i[0];
        CFG_OFFSET_MINUTES: offset_minutes_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage valids
  logic [7:0] vld_q, vld_d;
  assign vld_d = {vld_q[6:0], start & ~busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 1: input word
  logic [31:0] utc1_q;

  // stage 2: u = standard local time + one day (never negative)
  logic signed [34:0] zone_secs;
  logic signed [34:0] u_sum;
  logic [32:0]        u2_q, u2_d;

  always_comb begin
    zone_secs = 35'(zone_hours_q) * 35'sd3600;
    u_sum     = $signed({3'b000, utc1_q}) + zone_secs + 35'sd86400;
    u2_d      = u_sum[32:0];
  end

  // stage 3: day quotient, floor(u / 86400) = floor((u >> 7) / 675)
  logic [52:0] day_prod;
  logic [15:0] qd3_q;
  logic [32:0] u3_q;

  assign day_prod = 53'(u2_q[32:7]) * 53'(DayRecip);

  // stage 4: day start, weekday, civil day count
  logic [32:0] dayst4_d, dayst4_q;
  logic [32:0] u4_q;
  logic [2:0]  wday4_d, wday4_q;
  logic [16:0] civ;
  logic [15:0] c4_d, c4_q;

  always_comb begin
    dayst4_d = 33'(qd3_q) * 33'd86400;
    // (days + 4) mod 7 with days = qd - 1
    wday4_d  = mod7_18(18'(qd3_q) + 18'd3);
    civ      = 17'(qd3_q) + CivilBase;
    if (civ >= Day2100) begin
      civ = civ + 17'd1;
    end
    c4_d = civ[15:0];
  end

  // stage 5: hour >= 2 flag, four-year cycle index
  logic        late5_d, late5_q;
  logic [37:0] cyc_prod;
  logic [5:0]  cyc5_q;
  logic [15:0] c5_q;
  logic [2:0]  wday5_q;
  logic [32:0] u5_q;

  always_comb begin
    late5_d  = (u4_q - dayst4_q) >= 33'd7200;
    cyc_prod = 38'(c4_q) * 38'(CycRecip);
  end

  // stage 6: day within cycle
  logic [15:0] cbase;
  logic [10:0] r6_d, r6_q;
  logic        late6_q;
  logic [2:0]  wday6_q;
  logic [32:0] u6_q;

  always_comb begin
    cbase = 16'(cyc5_q) * 16'd1461;
    r6_d  = 11'(c5_q - cbase);
  end

  // stage 7: month and day of month
  logic [10:0] ybase;
  logic [8:0]  doy;
  logic [8:0]  mday_full;
  logic [3:0]  mp7_d, mp7_q;
  logic [4:0]  mday7_q;
  logic        late7_q;
  logic [2:0]  wday7_q;
  logic [32:0] u7_q;

  always_comb begin
    // leap day sits at the end of the cycle, so cap the year at 3
    priority if (r6_q >= 11'd1095) begin
      ybase = 11'd1095;
    end else if (r6_q >= 11'd730) begin
      ybase = 11'd730;
    end else if (r6_q >= 11'd365) begin
      ybase = 11'd365;
    end else begin
      ybase = 11'd0;
    end
    doy   = 9'(r6_q - ybase);
    mp7_d = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (doy >= month_start(4'(i))) begin
        mp7_d = 4'(i);
      end
    end
    mday_full = doy - month_start(mp7_d) + 9'd1;
  end

  // stage 8: DST decision and final sum
  logic [2:0]         fs_mod;
  logic [3:0]         first_sun;
  logic [4:0]         second_sun;
  logic               in_dst;
  logic               dst8_d;
  logic signed [34:0] loc_sum;
  logic               done_q;
  logic signed [33:0] local_q;
  logic               dst_q;

  always_comb begin
    fs_mod     = mod7_18(18'(mday7_q) + 18'd7 - 18'(wday7_q));
    first_sun  = (fs_mod == 3'd0) ? 4'd7 : {1'b0, fs_mod};
    second_sun = 5'(first_sun) + 5'd7;
    if (mp7_q == MpMarch) begin
      in_dst = (mday7_q > second_sun) || ((mday7_q == second_sun) && late7_q);
    end else if (mp7_q <= MpOct) begin
      in_dst = 1'b1;
    end else if (mp7_q == MpNov) begin
      in_dst = (mday7_q < 5'(first_sun)) ||
               ((mday7_q == 5'(first_sun)) && !late7_q);
    end else begin
      in_dst = 1'b0;
    end
    dst8_d  = dst_enable_q & in_dst;
    loc_sum = $signed({2'b00, u7_q}) - 35'sd86400
            + (dst8_d ? 35'sd3600 : 35'sd0)
            + 35'(offset_minutes_q) * 35'sd60;
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    utc1_q   <= utc_seconds_i;
    u2_q     <= u2_d;
    qd3_q    <= day_prod[51:36];
    u3_q     <= u2_q;
    dayst4_q <= dayst4_d;
    u4_q     <= u3_q;
    wday4_q  <= wday4_d;
    c4_q     <= c4_d;
    late5_q  <= late5_d;
    cyc5_q   <= cyc_prod[37:32];
    c5_q     <= c4_q;
    wday5_q  <= wday4_q;
    u5_q     <= u4_q;
    r6_q     <= r6_d;
    late6_q  <= late5_q;
    wday6_q  <= wday5_q;
    u6_q     <= u5_q;
    mp7_q    <= mp7_d;
    mday7_q  <= mday_full[4:0];
    late7_q  <= late6_q;
    wday7_q  <= wday6_q;
    u7_q     <= u6_q;
    local_q  <= loc_sum[33:0];
    dst_q    <= dst8_d;
  end

  assign done_q          = vld_q[7];
  assign done_o          = done_q;
  assign local_seconds_o = local_q;
  assign dst_active_o    = dst_q;

  `UTCL_ASSERT_IMP(a_latency, done_o, $past(start, 8), "result without a start 8 cycles before")
  `UTCL_ASSERT_IMP(a_wday_range, vld_q[4], wday5_q < 3'd7, "weekday out of range")
  `UTCL_ASSERT_IMP(a_dst_enabled, done_o && dst_active_o, $past(dst_enable_q), "DST hour added while disabled")
  `UTCL_ASSERT_IMP(a_dst_month, done_o && dst_active_o, $past(mp7_q) <= MpNov, "DST hour added outside March to November")

endmodule

[test/local_time_checker.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// local_time_checker
// Watches the timestamp, result and register channels of the UTC to local time
// block, predicts each result from its own register copy and compares in order.
// -----------------------------------------------------------------------------
module local_time_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic                          busy,
  input  logic [31:0]                   utc_seconds_i,
  input  logic                          done_o,
  input  logic signed [33:0]            local_seconds_o,
  input  logic                          dst_active_o,
  input  logic                          cfg_we_i,
  input  logic [utcl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [utcl_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            mismatches,
  output int                            pending,
  output int                            checked,
  output int                            dst_hits
);
  import utcl_pkg::*;

  localparam longint SecsPerDay  = 86400;
  localparam longint SecsPerHour = 3600;
  localparam longint SecsPerMin  = 60;

  typedef struct packed {
    logic signed [33:0] secs;
    logic               dst;
  } local_time_t;

  logic [4:0]  zone_hours_q;
  logic        dst_enable_q;
  logic [10:0] offset_min_q;

  local_time_t expected_local[$];

  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  // date of the first Sunday of the month; remainder 0 is the 7th
  function automatic int first_sunday(input int wday, input int mday);
    int r;
    r = (7 - wday + mday) % 7;
    return (r == 0) ? 7 : r;
  endfunction

  function automatic bit dst_in_effect(input int month, input int mday, input int wday,
                                       input int hour);
    int change_day;
    if (month < 3 || month > 11) begin
      return 1'b0;
    end
    if (month > 3 && month < 11) begin
      return 1'b1;
    end
    if (month == 3) begin
      change_day = first_sunday(wday, mday) + 7;
      if (mday != change_day) begin
        return mday > change_day;
      end
      return hour >= 2;
    end
    change_day = first_sunday(wday, mday);
    if (mday != change_day) begin
      return mday < change_day;
    end
    return hour < 2;
  endfunction

  function automatic local_time_t predict_local(input logic [31:0] utc);
    local_time_t res;
    longint      t, days, sod, z, era, doe, yoe, doy, mp;
    int          hour, wday, mday, month;
    bit          dst;
    t    = longint'(utc) + longint'($signed(zone_hours_q)) * SecsPerHour;
    days = floor_div(t, SecsPerDay);
    sod  = t - days * SecsPerDay;
    hour = int'(sod / SecsPerHour);
    wday = int'(days + 4 - floor_div(days + 4, 7) * 7);
    // civil date from day count, eras of 400 years starting 0000-03-01
    z     = days + 719468;
    era   = floor_div(z, 146097);
    doe   = z - era * 146097;
    yoe   = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy   = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp    = (5 * doy + 2) / 153;
    mday  = int'(doy - (153 * mp + 2) / 5 + 1);
    month = int'((mp < 10) ? mp + 3 : mp - 9);
    dst   = dst_enable_q && dst_in_effect(month, mday, wday, hour);
    if (dst) begin
      t = t + SecsPerHour;
    end
    t = t + longint'($signed(offset_min_q)) * SecsPerMin;
    res.secs = t[33:0];
    res.dst  = dst;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    local_time_t want;
    if (!rst_ni) begin
      zone_hours_q = '0;
      dst_enable_q = 1'b0;
      offset_min_q = '0;
      expected_local.delete();
      mismatches = 0;
      checked    = 0;
      dst_hits   = 0;
    end else begin
      if (done_o) begin
        if (expected_local.size() == 0) begin
          mismatches++;
          $display("%0t: result with no word pending, local_seconds %0d dst_active %0b",
                   $time, local_seconds_o, dst_active_o);
        end else begin
          want = expected_local.pop_front();
          checked++;
          if (want.dst) begin
            dst_hits++;
          end
          if (local_seconds_o !== want.secs) begin
            mismatches++;
            $display("%0t: local_seconds expected %0d actual %0d",
                     $time, $signed(want.secs), local_seconds_o);
          end
          if (dst_active_o !== want.dst) begin
            mismatches++;
            $display("%0t: dst_active expected %0b actual %0b",
                     $time, want.dst, dst_active_o);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ZONE_HOURS:     zone_hours_q = cfg_data_i[4:0];
          CFG_DST_ENABLE:     dst_enable_q = cfg_data_i[0];
          CFG_OFFSET_MINUTES: offset_min_q = cfg_data_i[10:0];
          default:            ;
        endcase
      end
      if (start && !busy) begin
        expected_local.push_back(predict_local(utc_seconds_i));
      end
    end
    pending = expected_local.size();
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Drives the UTC to local time block: a directed set of edge timestamps and
// DST change points, then random timestamps clustered around DST changes and
// midnights under many register settings, with random sender gaps.
// -----------------------------------------------------------------------------
module tb;
  import utcl_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;
  localparam int StallLimit    = 400;
  localparam int DrainCycles   = 16;
  localparam int RandomPhases  = 12;
  localparam int WordsPerPhase = 86;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                start         = 1'b0;
  logic                busy;
  logic [31:0]         utc_seconds_i = '0;
  logic                done_o;
  logic signed [33:0]  local_seconds_o;
  logic                dst_active_o;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  int mismatches, pending, checked, dst_hits;
  int zone_now;
  int words_sent;
  int settings;
  bit steady;

  utc_to_local_time_with_dst uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .utc_seconds_i   (utc_seconds_i),
    .done_o          (done_o),
    .local_seconds_o (local_seconds_o),
    .dst_active_o    (dst_active_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  local_time_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .utc_seconds_i   (utc_seconds_i),
    .done_o          (done_o),
    .local_seconds_o (local_seconds_o),
    .dst_active_o    (dst_active_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .mismatches      (mismatches),
    .pending         (pending),
    .checked         (checked),
    .dst_hits        (dst_hits)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // days since epoch of a civil date
  function automatic longint civil_days(input int y, input int m, input int d);
    int yy, era, yoe, doy, doe;
    yy  = (m <= 2) ? y - 1 : y;
    era = yy / 400;
    yoe = yy - era * 400;
    doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return longint'(era) * 146097 + doe - 719468;
  endfunction

  function automatic int sunday_date(input int y, input int m);
    int wd;
    wd = int'((civil_days(y, m, 1) + 4) % 7);
    return 1 + (7 - wd) % 7;
  endfunction

  // mostly DST change points and midnights in the current zone, some raw noise
  function automatic logic [31:0] pick_stamp();
    longint t;
    int     sel, y, m, d;
    sel = $urandom_range(0, 9);
    y   = $urandom_range(1970, 2105);
    if (sel < 6) begin
      m = (sel % 2) ? 11 : 3;
      d = sunday_date(y, m) + ((m == 3) ? 7 : 0);
      t = civil_days(y, m, d) * 86400 + 7200 - longint'(zone_now) * 3600;
      case ($urandom_range(0, 2))
        0:       t = t + longint'($urandom_range(0, 20)) - 10;
        1:       t = t + longint'($urandom_range(0, 7200)) - 3600;
        default: t = t + longint'($urandom_range(0, 1382400)) - 691200;
      endcase
    end else if (sel < 8) begin
      m = $urandom_range(1, 12);
      d = $urandom_range(1, 31);
      if (d > 28) begin
        // month end, rolls into the next month when too long
        t = civil_days(y, m, 28) * 86400 + longint'(d - 28) * 86400;
      end else begin
        t = civil_days(y, m, d) * 86400;
      end
      t = t - longint'(zone_now) * 3600 + longint'($urandom_range(0, 10)) - 5;
    end else if (sel == 8) begin
      t = longint'($urandom);
    end else begin
      t = $urandom_range(0, 1) ? longint'($urandom_range(0, 200000))
                               : 64'hFFFF_FFFF - longint'($urandom_range(0, 200000));
    end
    if (t < 0 || t > 64'hFFFF_FFFF) begin
      t = longint'($urandom);
    end
    return t[31:0];
  endfunction

  // stop sending and hold until every word has its result
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic send_word(input logic [31:0] v);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    utc_seconds_i <= v;
    do @(posedge clk_i); while (busy);
    words_sent++;
  endtask

  // standard local date and time in the current zone
  task automatic send_local(input int y, input int m, input int d,
                            input int hh, input int mm, input int ss);
    longint t;
    t = civil_days(y, m, d) * 86400 + hh * 3600 + mm * 60 + ss - longint'(zone_now) * 3600;
    send_word(t[31:0]);
  endtask

  // unused data bits are random; a write to the spare index must be ignored
  task automatic set_config(input int zh, input bit de, input int om);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ZONE_HOURS;
    cfg_data_i <= {6'($urandom), 5'(zh)};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_DST_ENABLE;
    cfg_data_i <= {10'($urandom), de};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_OFFSET_MINUTES;
    cfg_data_i <= 11'(om);
    @(posedge clk_i);
    cfg_idx_i  <= CfgIdxSpare;
    cfg_data_i <= 11'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    zone_now = int'($signed(5'(zh)));
    settings++;
  endtask

  // watchdog: cycles with no word, result or write
  initial begin
    int stall;
    stall = 0;
    while (stall < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || done_o || cfg_we_i) begin
        stall = 0;
      end else begin
        stall++;
      end
    end
    $display("%0t: no progress for %0d cycles", $time, StallLimit);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    words_sent = 0;
    settings   = 0;
    zone_now   = 0;
    steady     = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // widest negative zone and trim: local time before the epoch
    set_config(-12, 1'b1, -720);
    send_word(32'd0);
    send_word(32'd1);
    send_word(32'd43199);
    send_word(32'd43200);
    send_word(32'hFFFF_FFFF);
    // register values beyond the stated ranges
    set_config(15, 1'b1, 1023);
    send_word(32'hFFFF_FFFF);
    send_word(32'd0);
    set_config(-16, 1'b0, -1024);
    send_word(32'd0);
    send_word(32'hFFFF_FFFF);

    // DST change points, including months whose first Sunday is the 7th
    steady = 1'b0;
    set_config(-5, 1'b1, 0);
    send_local(2021, 3, 14, 1, 59, 59);
    send_local(2021, 3, 14, 2, 0, 0);
    send_local(2021, 11, 7, 1, 59, 59);
    send_local(2021, 11, 7, 2, 0, 0);
    send_local(2024, 3, 10, 1, 59, 59);
    send_local(2024, 3, 10, 2, 0, 0);
    send_local(2024, 11, 3, 1, 59, 59);
    send_local(2024, 11, 3, 2, 0, 0);
    send_local(2024, 12, 31, 23, 59, 59);
    send_local(2025, 1, 1, 0, 0, 0);
    // 2100 is not a leap year
    send_local(2100, 2, 28, 23, 59, 59);
    send_local(2100, 3, 1, 0, 0, 0);

    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: set_config(-12, 1'b1, -720);
        1: set_config(14, 1'b1, 720);
        2: set_config(15, 1'b1, 1023);
        3: set_config(-16, 1'b1, -1024);
        default: begin
          if ($urandom_range(0, 5) == 0) begin
            set_config(int'($urandom_range(0, 31)) - 16, 1'($urandom),
                       int'($urandom_range(0, 2047)) - 1024);
          end else begin
            set_config(int'($urandom_range(0, 26)) - 12, $urandom_range(0, 3) != 0,
                       int'($urandom_range(0, 1440)) - 720);
          end
        end
      endcase
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < WordsPerPhase; n++) begin
        if (p == RandomPhases / 2 && n == WordsPerPhase / 2) begin
          wait_drained();
        end
        if (n % 32 == 31) begin
          steady = ($urandom_range(0, 3) == 0);
        end
        send_word(pick_stamp());
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d timestamps under %0d register settings.", words_sent, settings);
    $display("Checked %0d results, %0d with the daylight saving hour added.",
             checked, dst_hits);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/utcl_pkg.sv
hw/rtl/utc_to_local_time_with_dst.sv
test/local_time_checker.sv
test/tb.sv
